>>> rtl/rlt_pkg.sv
// rlt_pkg: shared types and codes for the reference lifecycle tracker
// no dependencies; imported by rlt_lifecycle and reference_lifecycle_tracker
package rlt_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int AMOUNT_BITS    = 16;

  // command codes
  localparam logic [2:0] CMD_ADD_GC    = 3'd0;
  localparam logic [2:0] CMD_REM_GC    = 3'd1;
  localparam logic [2:0] CMD_ADD_VALID = 3'd2;
  localparam logic [2:0] CMD_REM_VALID = 3'd3;
  localparam logic [2:0] CMD_ADD_RES   = 3'd4;
  localparam logic [2:0] CMD_REM_RES   = 3'd5;

  // notice codes
  localparam logic [2:0] NOTE_NONE       = 3'd0;
  localparam logic [2:0] NOTE_ACTIVATE   = 3'd1;
  localparam logic [2:0] NOTE_VALIDATE   = 3'd2;
  localparam logic [2:0] NOTE_INVALIDATE = 3'd3;
  localparam logic [2:0] NOTE_DEACTIVATE = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
  localparam logic [1:0] STAT_DELETED   = 2'd3;

  // lifecycle states; pending states are only passed through within one command
  localparam logic [2:0] ST_INACTIVE       = 3'd0;
  localparam logic [2:0] ST_ACTIVE_INVALID = 3'd1;
  localparam logic [2:0] ST_VALID          = 3'd2;
  localparam logic [2:0] ST_DELETED        = 3'd7;

  typedef struct packed {
    logic [2:0]             cmd;
    logic [AMOUNT_BITS-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [2:0] notice;
    logic       last_of_run;
    logic       deleted_now;
    logic [1:0] status;
    logic [2:0] life_state;
  } out_item_t;

  // all results of one command, emitted one per cycle while out_ready is high
  typedef struct packed {
    logic [2:0] note0;
    logic [2:0] note1;
    logic [1:0] n_notes;
    logic       deleted;
    logic [1:0] status;
    logic [2:0] life;
  } bundle_t;

endpackage

>>> rtl/rlt_lifecycle.sv
// rlt_lifecycle: one command applied to the counters and lifecycle state
// combinational; depends on rlt_pkg
module rlt_lifecycle #(
  parameter int COUNT_BITS = rlt_pkg::COUNT_BITS_DEF
) (
  input  rlt_pkg::in_item_t  item,
  input  logic [COUNT_BITS-1:0] gc_cnt,
  input  logic [COUNT_BITS-1:0] valid_cnt,
  input  logic [COUNT_BITS-1:0] res_cnt,
  input  logic [2:0]            life,
  output logic [COUNT_BITS-1:0] gc_cnt_nxt,
  output logic [COUNT_BITS-1:0] valid_cnt_nxt,
  output logic [COUNT_BITS-1:0] res_cnt_nxt,
  output logic [2:0]            life_nxt,
  output rlt_pkg::bundle_t      bundle
);
  import rlt_pkg::*;

  localparam int W = ((COUNT_BITS > AMOUNT_BITS) ? COUNT_BITS : AMOUNT_BITS) + 1;

  // saturating add or remove; returns {status, new count}
  function automatic logic [COUNT_BITS+1:0] bump(input logic [COUNT_BITS-1:0] ctr,
                                                input logic [AMOUNT_BITS-1:0] amt,
                                                input logic add);
    logic [W-1:0] c_ext;
    logic [W-1:0] a_ext;
    logic [W-1:0] m_ext;
    logic [W-1:0] sum;
    c_ext = W'(ctr);
    a_ext = W'(amt);
    m_ext = W'({COUNT_BITS{1'b1}});
    sum   = c_ext + a_ext;
    if (add) begin
      if (sum > m_ext) return {STAT_OVERFLOW, {COUNT_BITS{1'b1}}};
      return {STAT_OK, sum[COUNT_BITS-1:0]};
    end
    if (a_ext > c_ext) return {STAT_UNDERFLOW, {COUNT_BITS{1'b0}}};
    return {STAT_OK, COUNT_BITS'(c_ext - a_ext)};
  endfunction

  logic [COUNT_BITS+1:0] bres;
  logic                  g;
  logic                  v;
  logic [2:0]            tgt;

  always_comb begin
    gc_cnt_nxt     = gc_cnt;
    valid_cnt_nxt  = valid_cnt;
    res_cnt_nxt    = res_cnt;
    life_nxt       = life;
    bundle         = '0;
    bundle.note0   = NOTE_NONE;
    bundle.note1   = NOTE_NONE;
    bundle.status  = STAT_OK;
    bres           = '0;
    g              = 1'b0;
    v              = 1'b0;
    tgt            = ST_INACTIVE;

    if (life == ST_DELETED) begin
      bundle.status = STAT_DELETED;
    end else begin
      unique case (item.cmd)
        CMD_ADD_GC, CMD_REM_GC, CMD_ADD_VALID, CMD_REM_VALID: begin
          if (item.cmd == CMD_ADD_GC || item.cmd == CMD_REM_GC) begin
            bres       = bump(gc_cnt, item.amount, item.cmd == CMD_ADD_GC);
            gc_cnt_nxt = bres[COUNT_BITS-1:0];
          end else begin
            bres          = bump(valid_cnt, item.amount, item.cmd == CMD_ADD_VALID);
            valid_cnt_nxt = bres[COUNT_BITS-1:0];
          end
          bundle.status = bres[COUNT_BITS+1:COUNT_BITS];
          g = |gc_cnt_nxt;
          v = |valid_cnt_nxt;
          // the machine settles where the two counters point unless the object is deleted
          tgt = v ? ST_VALID : (g ? ST_ACTIVE_INVALID : ST_INACTIVE);
          case (life)
            ST_INACTIVE: begin
              if (g || v) begin
                bundle.note0   = NOTE_ACTIVATE;
                bundle.note1   = NOTE_VALIDATE;
                bundle.n_notes = v ? 2'd2 : 2'd1;
              end
            end
            ST_ACTIVE_INVALID: begin
              if (v) begin
                bundle.note0   = NOTE_VALIDATE;
                bundle.n_notes = 2'd1;
              end else if (!g) begin
                bundle.note0   = NOTE_DEACTIVATE;
                bundle.n_notes = 2'd1;
              end
            end
            ST_VALID: begin
              if (!v) begin
                bundle.note0   = NOTE_INVALIDATE;
                bundle.note1   = NOTE_DEACTIVATE;
                bundle.n_notes = g ? 2'd1 : 2'd2;
              end
            end
            default: begin
            end
          endcase
          bundle.deleted = !g && !v && (res_cnt == '0);
          life_nxt       = bundle.deleted ? ST_DELETED : tgt;
        end
        CMD_ADD_RES, CMD_REM_RES: begin
          bres          = bump(res_cnt, item.amount, item.cmd == CMD_ADD_RES);
          res_cnt_nxt   = bres[COUNT_BITS-1:0];
          bundle.status = bres[COUNT_BITS+1:COUNT_BITS];
          if (item.cmd == CMD_REM_RES) begin
            bundle.deleted = (life == ST_INACTIVE) && (res_cnt_nxt == '0) &&
                             (gc_cnt == '0) && (valid_cnt == '0);
          end
          if (bundle.deleted) life_nxt = ST_DELETED;
        end
        default: begin
        end
      endcase
    end
    bundle.life = life_nxt;
  end

endmodule

>>> rtl/reference_lifecycle_tracker.sv
// reference_lifecycle_tracker: top level, input register, state and result sequencer
// depends on rlt_pkg and rlt_lifecycle
//
// Usage:
//   Commands enter on in_valid/in_ready/in_data (cmd, amount); results leave on
//   out_valid/out_ready/out_data. Each command gives zero to two notices and then
//   one final result with last_of_run set, one per cycle while out_ready is high.
//   A command waits in the input register, is applied to the counters and
//   lifecycle state when it moves to the result register, and its results
//   are offered from the result register.
//   Throughput: a command occupies the result register until its 1 to 3 results
//   have transferred; the next command is loaded in the cycle its predecessor's
//   final result transfers, so single-result commands flow at one per cycle
//   while out_ready is high. The result register's count of results sets the rate.
//   When out_ready is low the result register holds, the input register fills
//   and in_ready drops; nothing is lost.
//   Reset (rst_n low, synchronous) clears all counters, sets the lifecycle to
//   inactive and empties both registers.
module reference_lifecycle_tracker #(
  parameter int COUNT_BITS = rlt_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rlt_pkg::out_item_t out_data
);
  import rlt_pkg::*;

  logic                  in_vld_r;
  in_item_t              in_item_r;
  logic                  bnd_vld_r;
  bundle_t               bnd_r;
  logic [1:0]            idx_r;
  logic [COUNT_BITS-1:0] gc_r;
  logic [COUNT_BITS-1:0] valid_r;
  logic [COUNT_BITS-1:0] res_r;
  logic [2:0]            life_r;

  logic [COUNT_BITS-1:0] gc_nxt;
  logic [COUNT_BITS-1:0] valid_nxt;
  logic [COUNT_BITS-1:0] res_nxt;
  logic [2:0]            life_nxt;
  bundle_t               bnd_nxt;

  logic is_last;
  logic out_xfer;
  logic load;

  rlt_lifecycle #(
    .COUNT_BITS(COUNT_BITS)
  ) u_life (
    .item          (in_item_r),
    .gc_cnt        (gc_r),
    .valid_cnt     (valid_r),
    .res_cnt       (res_r),
    .life          (life_r),
    .gc_cnt_nxt    (gc_nxt),
    .valid_cnt_nxt (valid_nxt),
    .res_cnt_nxt   (res_nxt),
    .life_nxt      (life_nxt),
    .bundle        (bnd_nxt)
  );

  assign is_last  = (idx_r == bnd_r.n_notes);
  assign out_xfer = out_valid && out_ready;
  // result register frees when its final result transfers
  assign load     = in_vld_r && (!bnd_vld_r || (out_xfer && is_last));
  assign in_ready = !in_vld_r || load;

  assign out_valid = bnd_vld_r;
  always_comb begin
    out_data             = '0;
    out_data.notice      = NOTE_NONE;
    if (!is_last) out_data.notice = (idx_r == 2'd0) ? bnd_r.note0 : bnd_r.note1;
    out_data.last_of_run = is_last;
    out_data.deleted_now = is_last && bnd_r.deleted;
    out_data.status      = bnd_r.status;
    out_data.life_state  = bnd_r.life;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      bnd_vld_r <= 1'b0;
      idx_r     <= 2'd0;
      gc_r      <= '0;
      valid_r   <= '0;
      res_r     <= '0;
      life_r    <= ST_INACTIVE;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (load) begin
        bnd_vld_r <= 1'b1;
        idx_r     <= 2'd0;
        gc_r      <= gc_nxt;
        valid_r   <= valid_nxt;
        res_r     <= res_nxt;
        life_r    <= life_nxt;
      end else if (out_xfer) begin
        if (is_last) begin
          bnd_vld_r <= 1'b0;
          idx_r     <= 2'd0;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_item_r <= in_data;
    if (load) bnd_r <= bnd_nxt;
  end

  // lifecycle only rests in a stable state or deleted between commands
  a_stable_state: assert property (@(posedge clk) disable iff (!rst_n)
    life_r == ST_INACTIVE || life_r == ST_ACTIVE_INVALID ||
    life_r == ST_VALID || life_r == ST_DELETED)
    else $error("lifecycle register holds a pending state");

  // deletion is permanent
  a_deleted_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    life_r == ST_DELETED |=> life_r == ST_DELETED)
    else $error("object left the deleted state");

  // result index never runs past the final result
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bnd_vld_r |-> idx_r <= bnd_r.n_notes)
    else $error("result index past final result");

  // deletion is reported only on a final result and in the deleted state
  a_del_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.deleted_now |->
      out_data.last_of_run && out_data.life_state == ST_DELETED)
    else $error("deleted_now on a notice or outside deleted state");

endmodule
